### design/ictf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ictf_pkg
// Types, constants and the arctangent table of the tilt filter.
// ============================================================================
package ictf_pkg;

	localparam int AtanIterations = 16;
	localparam int CordicTableLen = 24;
	localparam int CordicSteps = (AtanIterations < CordicTableLen) ?
		AtanIterations : CordicTableLen;
	localparam int IterW = $clog2(CordicTableLen);
	localparam int CordicW = 42;
	localparam int ZW = 26;
	localparam logic [23:0] GyroDegQ40 = 24'd15749344;
	localparam logic signed [23:0] AngleMax = 24'sh7FFFFF;
	localparam logic signed [23:0] AngleMin = -24'sh800000;
	localparam int QueueDepth = 2;

	typedef enum logic {
		REG_MODE         = 1'b0,
		REG_ACCEL_WEIGHT = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
		logic [15:0]        step_time;
	} sample_t;

	typedef struct packed {
		logic signed [23:0] angle_x;
		logic signed [23:0] angle_y;
		logic signed [23:0] angle_z;
	} angles_t;

	// Front-to-back work entry: sample with accel_z sign folded into x/y.
	typedef struct packed {
		logic signed [16:0] num_x;
		logic signed [16:0] num_y;
		logic [15:0]        den;
		logic               den_zero;
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
		logic [15:0]        step_time;
	} work_t;

	function automatic logic [ZW-1:0] atan_entry(input logic [IterW-1:0] i);
		logic [ZW-1:0] r;
		case (i)
			5'd0:  r = 26'd2949120;
			5'd1:  r = 26'd1740967;
			5'd2:  r = 26'd919879;
			5'd3:  r = 26'd466945;
			5'd4:  r = 26'd234379;
			5'd5:  r = 26'd117304;
			5'd6:  r = 26'd58666;
			5'd7:  r = 26'd29335;
			5'd8:  r = 26'd14668;
			5'd9:  r = 26'd7334;
			5'd10: r = 26'd3667;
			5'd11: r = 26'd1833;
			5'd12: r = 26'd917;
			5'd13: r = 26'd458;
			5'd14: r = 26'd229;
			5'd15: r = 26'd115;
			5'd16: r = 26'd57;
			5'd17: r = 26'd29;
			5'd18: r = 26'd14;
			5'd19: r = 26'd7;
			5'd20: r = 26'd4;
			5'd21: r = 26'd2;
			5'd22: r = 26'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### design/ictf_front.sv
`timescale 1ns / 1ps
// ============================================================================
// ictf_front
// Accept a sample beat, fold the accel_z sign and register it into the queue.
// ============================================================================
module ictf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  ictf_pkg::sample_t in_data,
	input  logic              in_valid,
	output logic              in_ready,
	output ictf_pkg::work_t   out_data,
	output logic              out_valid,
	input  logic              out_ready
);
	import ictf_pkg::*;

	logic  valid_q;
	work_t data_q;
	work_t next_w;
	logic  neg;

	always_comb begin
		neg = in_data.accel_z[15];
		next_w.num_x = neg ? -{in_data.accel_x[15], in_data.accel_x} :
			{in_data.accel_x[15], in_data.accel_x};
		next_w.num_y = neg ? -{in_data.accel_y[15], in_data.accel_y} :
			{in_data.accel_y[15], in_data.accel_y};
		next_w.den = neg ? 16'(-in_data.accel_z) : 16'(in_data.accel_z);
		next_w.den_zero = (in_data.accel_z == 16'sd0);
		next_w.gyro_x = in_data.gyro_x;
		next_w.gyro_y = in_data.gyro_y;
		next_w.gyro_z = in_data.gyro_z;
		next_w.step_time = in_data.step_time;
	end

	assign in_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= next_w;
		end
	end

endmodule

### design/ictf_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// ictf_queue
// Short queue of work entries between the front and the back.
// ============================================================================
module ictf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  ictf_pkg::work_t wr_data,
	input  logic            wr_valid,
	output logic            wr_ready,
	output ictf_pkg::work_t rd_data,
	output logic            rd_valid,
	input  logic            rd_ready
);
	import ictf_pkg::*;

	localparam int PtrW = $clog2(QueueDepth);

	work_t            mem_q [QueueDepth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [PtrW:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = (count_q != (PtrW+1)'(QueueDepth));
	assign rd_valid = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (PtrW+1)'(do_wr) - (PtrW+1)'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### design/ictf_back.sv
`timescale 1ns / 1ps
// ============================================================================
// ictf_back
// Run the shared CORDIC for both tilts, then integrate each axis and, in
// complementary mode, blend it; hold the result beat until popped.
// ============================================================================
module ictf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ictf_pkg::work_t   in_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  logic [15:0]       accel_weight,
	output ictf_pkg::angles_t out_data,
	output logic              out_valid,
	input  logic              out_ready
);
	import ictf_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CORDIC, ST_PROD, ST_SCALE, ST_INTEG, ST_BLEND_A,
		ST_BLEND_B, ST_BLEND_SUM, ST_NEXT, ST_OUT
	} state_t;

	state_t                   state_q;
	work_t                    w_q;
	logic                     axis_y_q;
	logic [IterW-1:0]         iter_q;
	logic signed [CordicW-1:0] cx_q;
	logic signed [CordicW-1:0] cy_q;
	logic signed [ZW-1:0]     cz_q;
	logic signed [23:0]       tilt_q [2];
	logic [1:0]               ax_q;
	logic signed [31:0]       prod_q;
	logic signed [25:0]       delta_q;
	logic signed [23:0]       a_q;
	logic signed [41:0]       term_q;
	logic signed [41:0]       sum_q;
	logic signed [23:0]       store_q [3];
	angles_t                  res_q;
	logic                     out_valid_q;

	logic signed [CordicW-1:0] xs;
	logic signed [CordicW-1:0] ys;
	logic signed [ZW-1:0]     ang;
	logic signed [ZW-1:0]     zr;
	logic signed [15:0]       rate;
	logic signed [31:0]       pmul;
	logic [31:0]              mag;
	logic [55:0]              scaled;
	logic signed [25:0]       isum;
	logic signed [23:0]       isat;
	logic signed [23:0]       tilt_cur;
	logic signed [41:0]       bsum;
	logic signed [25:0]       bsh;
	logic signed [23:0]       bsat;

	always_comb begin
		xs = cx_q >>> iter_q;
		ys = cy_q >>> iter_q;
		ang = $signed(atan_entry(iter_q));
		zr = (cz_q + ZW'(128)) >>> 8;
		case (ax_q)
			2'd0: rate = w_q.gyro_x;
			2'd1: rate = w_q.gyro_y;
			default: rate = w_q.gyro_z;
		endcase
		pmul = rate * $signed({1'b0, w_q.step_time});
		mag = prod_q[31] ? 32'(-prod_q) : 32'(prod_q);
		scaled = (56'(mag) * 56'(GyroDegQ40) + (56'd1 << 39)) >> 40;
		isum = 26'(store_q[ax_q]) + delta_q;
		if (isum > 26'(AngleMax)) isat = AngleMax;
		else if (isum < 26'(AngleMin)) isat = AngleMin;
		else isat = isum[23:0];
		tilt_cur = (ax_q == 2'd2) ? 24'sd0 : tilt_q[ax_q[0]];
		bsum = sum_q + term_q + 42'sd32768;
		bsh = 26'(bsum >>> 16);
		if (bsh > 26'(AngleMax)) bsat = AngleMax;
		else if (bsh < 26'(AngleMin)) bsat = AngleMin;
		else bsat = bsh[23:0];
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			store_q[0] <= '0;
			store_q[1] <= '0;
			store_q[2] <= '0;
			axis_y_q <= 1'b0;
			iter_q <= '0;
			ax_q <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_OUT) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						w_q <= in_data;
						axis_y_q <= 1'b0;
						iter_q <= '0;
						cx_q <= CordicW'($signed({1'b0, in_data.den})) <<< 16;
						cy_q <= CordicW'(in_data.num_x) <<< 16;
						cz_q <= '0;
						state_q <= ST_CORDIC;
					end
				end
				ST_CORDIC: begin
					if (cy_q > 0) begin
						cx_q <= cx_q + ys;
						cy_q <= cy_q - xs;
						cz_q <= cz_q + ang;
					end else begin
						cx_q <= cx_q - ys;
						cy_q <= cy_q + xs;
						cz_q <= cz_q - ang;
					end
					if (iter_q == IterW'(CordicSteps - 1)) begin
						state_q <= ST_NEXT;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				ST_NEXT: begin
					if (!axis_y_q) begin
						tilt_q[0] <= w_q.den_zero ? 24'sd0 : 24'(zr);
						axis_y_q <= 1'b1;
						iter_q <= '0;
						cx_q <= CordicW'($signed({1'b0, w_q.den})) <<< 16;
						cy_q <= CordicW'(w_q.num_y) <<< 16;
						cz_q <= '0;
						state_q <= ST_CORDIC;
					end else begin
						tilt_q[1] <= w_q.den_zero ? 24'sd0 : 24'(zr);
						ax_q <= 2'd0;
						state_q <= ST_PROD;
					end
				end
				ST_PROD: begin
					prod_q <= pmul;
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					delta_q <= prod_q[31] ? -26'(scaled) : 26'(scaled);
					state_q <= ST_INTEG;
				end
				ST_INTEG: begin
					a_q <= isat;
					if (mode == 1'b0) begin
						state_q <= ST_BLEND_A;
					end else begin
						store_q[ax_q] <= isat;
						state_q <= ST_BLEND_SUM;
					end
				end
				ST_BLEND_A: begin
					sum_q <= a_q * $signed({1'b0, 17'h10000 - 17'(accel_weight)});
					state_q <= ST_BLEND_B;
				end
				ST_BLEND_B: begin
					term_q <= tilt_cur * $signed({1'b0, accel_weight});
					state_q <= ST_BLEND_SUM;
				end
				ST_BLEND_SUM: begin
					if (mode == 1'b0) store_q[ax_q] <= bsat;
					if (ax_q == 2'd2) begin
						state_q <= ST_OUT;
					end else begin
						ax_q <= ax_q + 1'b1;
						state_q <= ST_PROD;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						res_q.angle_x <= store_q[0];
						res_q.angle_y <= store_q[1];
						res_q.angle_z <= store_q[2];
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### design/imu_complementary_tilt_filter_top.sv
`timescale 1ns / 1ps
// ============================================================================
// imu_complementary_tilt_filter_top
// Three-axis complementary tilt filter with queue-style ports.
// ============================================================================
// In the back end a sample is accepted and run through two passes of one
// shared 16-step CORDIC (one step per cycle, with a hand-over state after
// each pass) for the x and y tilts, then per axis through six steps (four in
// gyro-only mode, which skips the two blend products); the result is then
// loaded into the output register. Samples are accepted into a two-entry
// queue while the back end works, and one finished result beat waits in an
// output register until popped; the back end holds with its next result
// while that beat waits. Angles are 1/256 degree, saturated to 24 bits.
module imu_complementary_tilt_filter_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  ictf_pkg::sample_t sample,
	output logic              empty,
	input  logic              pop,
	output ictf_pkg::angles_t angles,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data
);
	import ictf_pkg::*;

	logic        mode_q;
	logic [15:0] accel_weight_q;
	work_t       f_data, q_data;
	logic        f_valid, f_ready, q_valid, q_ready, in_ready, out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			accel_weight_q <= 16'd1311;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_MODE:         mode_q <= cfg_data[0];
				REG_ACCEL_WEIGHT: accel_weight_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ictf_front u_front (
		.clk(clk), .arst_n(arst_n), .in_data(sample), .in_valid(push),
		.in_ready(in_ready), .out_data(f_data), .out_valid(f_valid),
		.out_ready(f_ready)
	);

	ictf_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_data(f_data), .wr_valid(f_valid),
		.wr_ready(f_ready), .rd_data(q_data), .rd_valid(q_valid),
		.rd_ready(q_ready)
	);

	ictf_back u_back (
		.clk(clk), .arst_n(arst_n), .in_data(q_data), .in_valid(q_valid),
		.in_ready(q_ready), .mode(mode_q), .accel_weight(accel_weight_q),
		.out_data(angles), .out_valid(out_valid), .out_ready(pop)
	);

	assign full = !in_ready;
	assign empty = !out_valid;

endmodule
